/* sv/frame_motion_detector_unit_defines.svh */
// Assertion macros shared by the frame motion detector modules
`ifndef FRAME_MOTION_DETECTOR_UNIT_DEFINES_SVH
`define FRAME_MOTION_DETECTOR_UNIT_DEFINES_SVH

// Condition must hold at every edge out of reset
`define FMD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("fmd check failed");

// Consequent must hold at the clock edge following the antecedent
`define FMD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fmd check failed");

`endif

/* sv/fmd_pkg.sv */
// Shared types, constants and helpers of the frame motion detector
`timescale 1ns / 1ps
package fmd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;
    localparam int THR_W      = 17;
    localparam int CNT_W      = 21;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QLVL_W     = $clog2(QDEPTH + 1);
    localparam int LINE_W     = 24;

    localparam logic [1:0] CFG_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    // One column of the 3x3 neighborhood plus position flags
    typedef struct packed {
        logic [7:0] g0;       // grey two rows up
        logic [7:0] g1;       // grey one row up
        logic [7:0] g2;       // grey of this row
        logic [7:0] bg_up;    // background one row up
        logic [7:0] bg_lo;    // background of this row
        logic       row_ge1;
        logic       row_ge2;
        logic       col_ge1;
        logic       col_ge2;
        logic       last_col;
        logic       last_row;
    } t_col;

    function automatic logic [DIM_W-1:0] f_clamp(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] vmax);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) res = DIM_W'(1);
        else if (v > vmax) res = vmax;
        return res;
    endfunction

    // Q16 reciprocal of the window size, exact for sums below 32768
    function automatic logic [16:0] f_recip(input logic [1:0] rows,
                                            input logic [1:0] cols);
        logic [3:0]  n;
        logic [16:0] res;
        n = 4'(rows) * 4'(cols);
        unique case (n)
            4'd1:    res = 17'd65536;
            4'd2:    res = 17'd32768;
            4'd3:    res = 17'd21846;
            4'd4:    res = 17'd16384;
            4'd6:    res = 17'd10923;
            4'd9:    res = 17'd7282;
            default: res = 17'd0;
        endcase
        return res;
    endfunction

endpackage

/* sv/fmd_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module fmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/fmd_front.sv */
// Front end: pixel intake, grey conversion, line store and column assembly
`timescale 1ns / 1ps
module fmd_front import fmd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_blue,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_background_pixel,
    input  logic [DIM_W-1:0]  i_width,
    input  logic [DIM_W-1:0]  i_height,
    input  logic              i_clear,
    input  logic [QLVL_W-1:0] i_q_level,
    output logic              o_push,
    output t_col              o_item
);
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_s1_valid;
    logic [7:0]        r_s1_grey, r_s1_bg;
    logic [COL_W-1:0]  r_s1_col;
    logic              r_s1_r1, r_s1_r2, r_s1_c1, r_s1_c2, r_s1_lc, r_s1_lr;
    logic              r_fwd;
    logic [LINE_W-1:0] r_fwd_data;
    logic              accept, last_col, last_row;
    logic [9:0]        chan_sum;
    logic [19:0]       grey_prod;
    logic [LINE_W-1:0] ram_rdata, line_rd, line_wr;

    assign o_ready  = (QLVL_W'(i_q_level) + QLVL_W'(r_s1_valid)) < QLVL_W'(QDEPTH);
    assign accept   = i_valid && o_ready;
    assign last_col = {1'b0, r_col} == (i_width - DIM_W'(1));
    assign last_row = {1'b0, r_row} == (i_height - DIM_W'(1));

    // floor(sum/3) as a reciprocal multiply, exact for sums up to 765
    assign chan_sum  = 10'(i_blue) + 10'(i_green) + 10'(i_red);
    assign grey_prod = 20'(chan_sum) * 20'd683;

    always_comb begin
        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_fwd      <= accept && r_s1_valid && (r_s1_col == r_col);
            if (i_clear) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= line_wr;
        if (accept) begin
            r_s1_grey <= grey_prod[18:11];
            r_s1_bg   <= i_background_pixel;
            r_s1_col  <= r_col;
            r_s1_r1   <= r_row != '0;
            r_s1_r2   <= r_row >= ROW_W'(2);
            r_s1_c1   <= r_col != '0;
            r_s1_c2   <= r_col >= COL_W'(2);
            r_s1_lc   <= last_col;
            r_s1_lr   <= last_row;
        end
    end

    // Line word: {grey row above, grey two rows above, background row above}
    assign line_rd = r_fwd ? r_fwd_data : ram_rdata;
    assign line_wr = {r_s1_grey, line_rd[23:16], r_s1_bg};

    fmd_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (line_wr),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign o_push          = r_s1_valid;
    assign o_item.g0       = line_rd[15:8];
    assign o_item.g1       = line_rd[23:16];
    assign o_item.g2       = r_s1_grey;
    assign o_item.bg_up    = line_rd[7:0];
    assign o_item.bg_lo    = r_s1_bg;
    assign o_item.row_ge1  = r_s1_r1;
    assign o_item.row_ge2  = r_s1_r2;
    assign o_item.col_ge1  = r_s1_c1;
    assign o_item.col_ge2  = r_s1_c2;
    assign o_item.last_col = r_s1_lc;
    assign o_item.last_row = r_s1_lr;
endmodule

/* sv/fmd_queue.sv */
// Short queue of column items between front and back
`timescale 1ns / 1ps
`include "frame_motion_detector_unit_defines.svh"
module fmd_queue import fmd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_col              i_item,
    input  logic              i_pop,
    output t_col              o_item,
    output logic              o_nonempty,
    output logic [QLVL_W-1:0] o_level
);
    t_col              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QLVL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + QPTR_W'(1);
            if (i_pop)  r_rptr <= r_rptr + QPTR_W'(1);
            r_level <= r_level + QLVL_W'(i_push) - QLVL_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_item;
    end

    assign o_item     = r_mem[r_rptr];
    assign o_nonempty = r_level != '0;
    assign o_level    = r_level;

    `FMD_ASSERT_ALWAYS(a_no_overflow, !(i_push && !i_pop && r_level == QLVL_W'(QDEPTH)))
    `FMD_ASSERT_ALWAYS(a_no_underflow, !(i_pop && r_level == '0))
endmodule

/* sv/fmd_back.sv */
// Back end: window sums, box mean, background compare, count and result
`timescale 1ns / 1ps
`include "frame_motion_detector_unit_defines.svh"
module fmd_back import fmd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_col             i_item,
    input  logic             i_nonempty,
    output logic             o_pop,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    input  logic [THR_W-1:0] i_threshold,
    input  logic             i_clear,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_motion,
    output logic [CNT_W-1:0] o_differing_pixels
);
    localparam int PROD_W = THR_W + 2 * DIM_W;

    logic [7:0]        r_p1g0, r_p1g1, r_p1g2, r_p2g0, r_p2g1, r_p2g2;
    logic [7:0]        r_p1bu, r_p1bl;
    logic              r_s1_valid, r_s1_eof;
    logic [11:0]       r_s1_sum [4];
    logic [16:0]       r_s1_rcp [4];
    logic [7:0]        r_s1_bg  [4];
    logic [3:0]        r_s1_act;
    logic              r_s2_valid, r_s2_eof;
    logic [7:0]        r_s2_mean [4];
    logic [7:0]        r_s2_bg   [4];
    logic [3:0]        r_s2_act;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid, r_out_motion;
    logic [CNT_W-1:0]  r_out_cnt;
    logic [THR_W+DIM_W-1:0] r_tw;
    logic [PROD_W-1:0] r_twh;

    logic              en;
    logic [9:0]        up_cur, up_p1, up_p2;
    logic [8:0]        lo_cur, lo_p1, lo_p2;
    logic [11:0]       sum_a, sum_b, sum_c, sum_d;
    logic [1:0]        rows_u, rows_l, cols_a, cols_b;
    logic [28:0]       prod [4];
    logic [2:0]        ndiff;
    logic [CNT_W-1:0]  total;

    // Stall only when a frame result is ready and the output slot is taken
    assign en    = !(r_s2_valid && r_s2_eof && r_out_valid && !i_ready);
    assign o_pop = en && i_nonempty;

    always_comb begin
        up_cur = 10'(i_item.row_ge2 ? i_item.g0 : 8'd0) + 10'(i_item.g1) + 10'(i_item.g2);
        up_p1  = 10'(i_item.row_ge2 ? r_p1g0 : 8'd0) + 10'(r_p1g1) + 10'(r_p1g2);
        up_p2  = 10'(i_item.row_ge2 ? r_p2g0 : 8'd0) + 10'(r_p2g1) + 10'(r_p2g2);
        lo_cur = 9'(i_item.row_ge1 ? i_item.g1 : 8'd0) + 9'(i_item.g2);
        lo_p1  = 9'(i_item.row_ge1 ? r_p1g1 : 8'd0) + 9'(r_p1g2);
        lo_p2  = 9'(i_item.row_ge1 ? r_p2g1 : 8'd0) + 9'(r_p2g2);
        sum_a  = 12'(i_item.col_ge2 ? up_p2 : 10'd0) + 12'(up_p1) + 12'(up_cur);
        sum_b  = 12'(i_item.col_ge1 ? up_p1 : 10'd0) + 12'(up_cur);
        sum_c  = 12'(i_item.col_ge2 ? lo_p2 : 9'd0) + 12'(lo_p1) + 12'(lo_cur);
        sum_d  = 12'(i_item.col_ge1 ? lo_p1 : 9'd0) + 12'(lo_cur);
        rows_u = i_item.row_ge2 ? 2'd3 : 2'd2;
        rows_l = i_item.row_ge1 ? 2'd2 : 2'd1;
        cols_a = i_item.col_ge2 ? 2'd3 : 2'd2;
        cols_b = i_item.col_ge1 ? 2'd2 : 2'd1;
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k] = 29'(r_s1_sum[k]) * 29'(r_s1_rcp[k]);
        end
        ndiff = '0;
        for (int k = 0; k < 4; k++) begin
            ndiff = ndiff + 3'(r_s2_act[k] && (r_s2_mean[k] != r_s2_bg[k]));
        end
        total = r_count + CNT_W'(ndiff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_s1_valid <= o_pop;
                r_s2_valid <= r_s1_valid;
            end
            if (!i_clear && en && r_s2_valid && r_s2_eof) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_clear) begin
                r_count <= '0;
            end else if (en && r_s2_valid) begin
                r_count <= r_s2_eof ? '0 : total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tw  <= (THR_W + DIM_W)'(i_threshold) * (THR_W + DIM_W)'(i_width);
        r_twh <= PROD_W'(r_tw) * PROD_W'(i_height);
        if (o_pop) begin
            // advance the column window
            r_p2g0 <= r_p1g0;
            r_p2g1 <= r_p1g1;
            r_p2g2 <= r_p1g2;
            r_p1g0 <= i_item.g0;
            r_p1g1 <= i_item.g1;
            r_p1g2 <= i_item.g2;
            r_p1bu <= i_item.bg_up;
            r_p1bl <= i_item.bg_lo;
        end
        if (en) begin
            r_s1_eof    <= i_item.last_row && i_item.last_col;
            r_s1_sum[0] <= sum_a;
            r_s1_sum[1] <= sum_b;
            r_s1_sum[2] <= sum_c;
            r_s1_sum[3] <= sum_d;
            r_s1_rcp[0] <= f_recip(rows_u, cols_a);
            r_s1_rcp[1] <= f_recip(rows_u, cols_b);
            r_s1_rcp[2] <= f_recip(rows_l, cols_a);
            r_s1_rcp[3] <= f_recip(rows_l, cols_b);
            r_s1_bg[0]  <= r_p1bu;
            r_s1_bg[1]  <= i_item.bg_up;
            r_s1_bg[2]  <= r_p1bl;
            r_s1_bg[3]  <= i_item.bg_lo;
            r_s1_act[0] <= i_item.row_ge1 && i_item.col_ge1;
            r_s1_act[1] <= i_item.row_ge1 && i_item.last_col;
            r_s1_act[2] <= i_item.last_row && i_item.col_ge1;
            r_s1_act[3] <= i_item.last_row && i_item.last_col;
            r_s2_eof    <= r_s1_eof;
            r_s2_act    <= r_s1_act;
            for (int k = 0; k < 4; k++) begin
                r_s2_mean[k] <= prod[k][23:16];
                r_s2_bg[k]   <= r_s1_bg[k];
            end
        end
        if (en && r_s2_valid && r_s2_eof) begin
            r_out_cnt    <= total;
            r_out_motion <= {2'b00, total, 16'd0} > r_twh;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_motion           = r_out_motion;
    assign o_differing_pixels = r_out_cnt;

    `FMD_ASSERT_NEXT(a_hold_eof, r_s2_valid && r_s2_eof && r_out_valid && !i_ready,
                     r_s2_valid && r_s2_eof)
    `FMD_ASSERT_NEXT(a_result_lands, en && r_s2_valid && r_s2_eof && !i_clear, r_out_valid)
endmodule

/* sv/frame_motion_detector_unit.sv */
// Frame motion detector: pixel input, config registers, result output
//
// Input channel (i_valid / o_ready): one colour pixel per transfer in raster
// order, with the background grey value at that position.
// Output channel (o_valid / i_ready): one transfer per frame, after the last
// pixel, carrying the differing-pixel count and the motion flag.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 frame
// width, 1 frame height, 2 threshold in Q1.16. Writing width or height
// restarts the frame. Write only while the block is idle.
// Throughput: one pixel per cycle unless the output stalls; the single line RAM
// takes one read and one write each cycle.
// The result register loads once the last column clears the queue, s1 and s2.
// A four-entry column queue separates intake from the window/compare path.
// If the receiver stalls, the result waits in the output register; intake
// continues until the next frame's result reaches the back end, then the
// queue fills and o_ready drops.
// Reset: positions and count clear, width 640, height 480, threshold 0.
`timescale 1ns / 1ps
module frame_motion_detector_unit import fmd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_blue,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_background_pixel,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_motion,
    output logic [CNT_W-1:0] o_differing_pixels,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [THR_W-1:0] i_cfg_data
);
    logic [DIM_W-1:0]  r_width, r_height;
    logic [THR_W-1:0]  r_threshold;
    logic [DIM_W-1:0]  width_eff, height_eff;
    logic              cfg_wr, size_wr;
    logic              push, pop, nonempty;
    logic [QLVL_W-1:0] q_level;
    t_col              push_item, head_item;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign size_wr     = cfg_wr && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= DIM_W'(640);
            r_height    <= DIM_W'(480);
            r_threshold <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_WIDTH:     r_width     <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:    r_height    <= i_cfg_data[DIM_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    assign width_eff  = f_clamp(r_width, DIM_W'(MAX_WIDTH));
    assign height_eff = f_clamp(r_height, DIM_W'(MAX_HEIGHT));

    fmd_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_blue             (i_blue),
        .i_green            (i_green),
        .i_red              (i_red),
        .i_background_pixel (i_background_pixel),
        .i_width            (width_eff),
        .i_height           (height_eff),
        .i_clear            (size_wr),
        .i_q_level          (q_level),
        .o_push             (push),
        .o_item             (push_item)
    );

    fmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (push_item),
        .i_pop      (pop),
        .o_item     (head_item),
        .o_nonempty (nonempty),
        .o_level    (q_level)
    );

    fmd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item             (head_item),
        .i_nonempty         (nonempty),
        .o_pop              (pop),
        .i_width            (width_eff),
        .i_height           (height_eff),
        .i_threshold        (r_threshold),
        .i_clear            (size_wr),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_motion           (o_motion),
        .o_differing_pixels (o_differing_pixels)
    );
endmodule

/* dv/frame_motion_detector_unit_test.sv */
// Testbench of the frame motion detector: random frames checked against a behavioral predictor
`timescale 1ns / 1ps
module frame_motion_detector_unit_test;
    import fmd_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;

    // Behavioral predictor of the frame statistics plus a queue of pending frame results
    class motion_scoreboard;
        int unsigned width_reg, height_reg, thresh_reg;
        logic [7:0]  grey_rows[3][MAX_WIDTH];
        logic [7:0]  bg_rows[2][MAX_WIDTH];
        int unsigned col, row, diff_count;
        logic        motion_q[$];
        int unsigned count_q[$];
        int          errors;

        function new();
            width_reg = 640;
            height_reg = 480;
            thresh_reg = 0;
            col = 0;
            row = 0;
            diff_count = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function int unsigned clamp_dim(int unsigned v, int unsigned vmax);
            if (v == 0) return 1;
            if (v > vmax) return vmax;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [THR_W-1:0] data);
            if (idx == CFG_WIDTH || idx == CFG_HEIGHT) begin
                if (idx == CFG_WIDTH) width_reg = data[DIM_W-1:0];
                else height_reg = data[DIM_W-1:0];
                col = 0;
                row = 0;
                diff_count = 0;
            end else if (idx == CFG_THRESHOLD) begin
                thresh_reg = data;
            end
        endfunction

        function void judge(int unsigned i, int unsigned j, int unsigned w, int unsigned h);
            int unsigned y0, y1, x0, x1, sum, n;
            y0 = (i > 0) ? i - 1 : 0;
            y1 = (i + 1 < h) ? i + 1 : h - 1;
            x0 = (j > 0) ? j - 1 : 0;
            x1 = (j + 1 < w) ? j + 1 : w - 1;
            sum = 0;
            n = 0;
            for (int unsigned y = y0; y <= y1; y++)
                for (int unsigned x = x0; x <= x1; x++) begin
                    sum += grey_rows[y % 3][x];
                    n++;
                end
            if (sum / n != bg_rows[i % 2][j])
                diff_count = (diff_count + 1) & 21'h1FFFFF;
        endfunction

        function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic [7:0] bg);
            int unsigned w, h, c, rw;
            longint unsigned lhs, rhs;
            w = clamp_dim(width_reg, MAX_WIDTH);
            h = clamp_dim(height_reg, MAX_HEIGHT);
            c = col;
            rw = row;
            grey_rows[rw % 3][c] = 8'((int'(b) + int'(g) + int'(r)) / 3);
            bg_rows[rw % 2][c] = bg;
            if (rw >= 1) begin
                if (c >= 1) judge(rw - 1, c - 1, w, h);
                if (c == w - 1) judge(rw - 1, c, w, h);
            end
            if (rw == h - 1) begin
                if (c >= 1) judge(rw, c - 1, w, h);
                if (c == w - 1) judge(rw, c, w, h);
            end
            if (c + 1 < w) begin
                col = c + 1;
                return;
            end
            col = 0;
            if (rw + 1 < h) begin
                row = rw + 1;
                return;
            end
            row = 0;
            lhs = longint'(diff_count) * 65536;
            rhs = longint'(thresh_reg) * w * h;
            motion_q.push_back(lhs > rhs);
            count_q.push_back(diff_count);
            diff_count = 0;
        endfunction

        task check_result(logic motion, logic [CNT_W-1:0] count);
            if (count_q.size() == 0) begin
                report($sformatf("unexpected frame result motion=%0b count=%0d", motion, count));
                return;
            end
            if (motion !== motion_q[0])
                report($sformatf("motion %0b, expected %0b", motion, motion_q[0]));
            if (count !== CNT_W'(count_q[0]))
                report($sformatf("differing count %0d, expected %0d", count, count_q[0]));
            void'(motion_q.pop_front());
            void'(count_q.pop_front());
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [7:0]       i_blue = '0, i_green = '0, i_red = '0, i_background_pixel = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic             o_motion;
    logic [CNT_W-1:0] o_differing_pixels;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index = '0;
    logic [THR_W-1:0] i_cfg_data = '0;

    motion_scoreboard sb = new();
    bit  steady = 1'b0;
    int  cycles = 0;
    int  pixels_sent = 0;

    frame_motion_detector_unit u_dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[frame_motion_detector_unit] ERROR");
            $finish;
        end
    end

    // Result sink with random back-pressure
    always @(posedge i_clk)
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_motion, o_differing_pixels);

    always @(negedge i_clk)
        i_ready <= steady || ($urandom_range(0, 99) >= 34);

    task send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic [7:0] bg);
        while (!steady && $urandom_range(0, 99) < 34) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_blue = b;
        i_green = g;
        i_red = r;
        i_background_pixel = bg;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(b, g, r, bg);
        pixels_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Drain pending results, then let the pipeline settle before a register write
    task wait_idle();
        while (sb.count_q.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task write_reg(logic [1:0] idx, logic [THR_W-1:0] data);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Fill a frame: random pixels in mode 0, else flat areas that make the smoothed grey match the background often
    task send_frame(int npix, int mode);
        logic [7:0] base, v, bgv;
        base = 8'($urandom);
        for (int k = 0; k < npix; k++) begin
            if (mode == 0) begin
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                v = ($urandom_range(0, 9) == 0) ? 8'($urandom) : base;
                bgv = ($urandom_range(0, 7) == 0) ? 8'($urandom) : base;
                if (mode == 2) begin
                    v = 8'hFF;
                    bgv = 8'hFF;
                end
                send_pixel(v, v, v, bgv);
            end
        end
    endtask

    task config_frame(int w, int h, int thr);
        write_reg(CFG_WIDTH, THR_W'(w));
        write_reg(CFG_HEIGHT, THR_W'(h));
        write_reg(CFG_THRESHOLD, THR_W'(thr));
    endtask

    initial begin
        int w, h, dw, dh;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // single-pixel frames with channel extremes
        config_frame(1, 1, 0);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF);
        config_frame(0, 0, 65536);
        send_frame(2, 0);
        write_reg(CFG_UNUSED, 17'h1FFFF);
        send_frame(1, 1);
        config_frame(3, 3, 1);
        send_frame(9, 1);
        send_frame(9, 2);
        // abandon a frame partway, then restart it
        send_frame(4, 0);
        write_reg(CFG_HEIGHT, THR_W'(3));
        send_frame(9, 0);
        // oversize width acts as the maximum
        config_frame(2047, 1, 17'h1FFFF);
        steady = 1'b1;
        send_frame(1024, 1);
        steady = 1'b0;

        while (pixels_sent < 1750) begin
            steady = (pixels_sent > 1300 && pixels_sent < 1450);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            dw = (w == int'(sb.width_reg)) ? 0 : 1;
            dh = (h == int'(sb.height_reg)) ? 0 : 1;
            if (dw) write_reg(CFG_WIDTH, THR_W'(w));
            if (dh) write_reg(CFG_HEIGHT, THR_W'(h));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_THRESHOLD, THR_W'($urandom));
                1: write_reg(CFG_THRESHOLD, THR_W'($urandom_range(0, 65536)));
                default: ;
            endcase
            if ($urandom_range(0, 9) == 0) send_frame($urandom_range(0, w * h - 1), 0);
            if (sb.col != 0 || sb.row != 0) write_reg(CFG_WIDTH, THR_W'(w));
            repeat ($urandom_range(1, 3)) send_frame(w * h, $urandom_range(0, 1));
        end
        steady = 1'b0;

        while (sb.count_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("[frame_motion_detector_unit] OK");
        end else begin
            $display("[frame_motion_detector_unit] ERROR");
        end
        $finish;
    end
endmodule
